// ----- rtl/core/pfs_pkg.sv -----
package pfs_pkg;

   // Default store geometry
   localparam int PFS_MAX_WIDTH  = 128;
   localparam int PFS_MAX_HEIGHT = 64;

   // Register reset values
   localparam logic [7:0] CFG_WIDTH_RST  = 8'd128;
   localparam logic [7:0] CFG_HEIGHT_RST = 8'd64;

   // Register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Operation codes
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_CLEAR   = 3'd1;
   localparam logic [2:0] MODE_PIXEL   = 3'd2;
   localparam logic [2:0] MODE_DIRTY   = 3'd3;
   localparam logic [2:0] MODE_SERVICE = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_CFG = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;

   // Bus bytes
   localparam logic [7:0] CMD_PREFIX      = 8'h00;
   localparam logic [7:0] DATA_PREFIX     = 8'h40;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'hae;
   localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
   localparam logic [7:0] CMD_HORIZONTAL  = 8'h00;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'haf;
   localparam logic [7:0] CMD_PAGE_BASE   = 8'hb0;
   localparam logic [7:0] CMD_COL_LOW     = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH    = 8'h10;

   localparam logic [3:0] BYTES_PER_RESULT = 4'd8;
   localparam logic [3:0] CMD_BYTES        = 4'd2;
   localparam logic [1:0] INIT_CMD_LAST    = 2'd3;
   localparam logic [1:0] SVC_CMD_LAST     = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic       pixel_on;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        dirty_now;
      logic [3:0]  byte_count;
      logic [63:0] payload;
      logic        transfer_start;
      logic        last;
   } rsp_item_type;

   // Command byte of the init sequence or of the page header
   function automatic logic [7:0] cmd_byte(input logic is_init, input logic [1:0] idx,
                                           input logic [7:0] page);
      logic [7:0] res;
      res = CMD_PREFIX;
      if (is_init) begin
         case (idx)
            2'd0:    res = CMD_DISPLAY_OFF;
            2'd1:    res = CMD_ADDR_MODE;
            2'd2:    res = CMD_HORIZONTAL;
            default: res = CMD_DISPLAY_ON;
         endcase
      end else begin
         case (idx)
            2'd0:    res = CMD_PAGE_BASE + page;
            2'd1:    res = CMD_COL_LOW;
            default: res = CMD_COL_HIGH;
         endcase
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/pfs_if.sv -----
interface pfs_req_if;
   import pfs_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pfs_rsp_if;
   import pfs_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pfs_addr_unit.sv -----
module pfs_addr_unit #(
   parameter int PAGE_W = 3,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              start,
   input  logic [PAGE_W-1:0] page,
   input  logic [7:0]        col,
   input  logic [7:0]        width,
   output logic [ADDR_W-1:0] result
);
   import pfs_pkg::*;

   localparam int SUM_W = PAGE_W + 9;

   logic [SUM_W-1:0]  sum_wide;
   logic [ADDR_W-1:0] result_ff;
   logic [ADDR_W-1:0] result_in;

   // byte address = page * width + column
   always_comb begin
      sum_wide  = SUM_W'(page) * SUM_W'(width) + SUM_W'(col);
      result_in = ADDR_W'(sum_wide);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/core/pfs_store.sv -----
module pfs_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import pfs_pkg::*;

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/page_framebuffer_scanout.sv -----
// Page-organised monochrome framebuffer with scan-out. One item is taken at a time; ready is
// high only while the sequencer is idle, and the result register lets the next item in while
// the final result still waits. Init takes the item and sweeps the store to zero, then sends
// its four command results; clear takes the item, runs the same sweep and sends one result.
// Set pixel runs address multiply, read, write back, result. Service of a dirty page takes
// the item, sends three command results, then reads its data bytes through the store's single
// read port and packs them, after the data prefix, into results of up to eight bytes, each
// sent once its last read has landed. Mark dirty, service of a clean store and rejected items
// take the item and send one result. A stalled result channel adds its stall to any of these.
// The store holds nothing meaningful after reset; the first successful init clears it.
module page_framebuffer_scanout #(
   parameter int MAX_WIDTH  = pfs_pkg::PFS_MAX_WIDTH,
   parameter int MAX_HEIGHT = pfs_pkg::PFS_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   pfs_req_if.sink          req_chan,
   pfs_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [7:0]       csr_wr_data
);
   import pfs_pkg::*;

   localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT / 8;
   localparam int MAX_PAGES   = MAX_HEIGHT / 8;
   localparam int PAGE_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [7:0] MAX_W8 = 8'(MAX_WIDTH);
   localparam logic [7:0] MAX_H8 = 8'(MAX_HEIGHT);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_PX_RD = 3'd2;
   localparam logic [2:0] S_PX_WR = 3'd3;
   localparam logic [2:0] S_CMD   = 3'd4;
   localparam logic [2:0] S_DATA  = 3'd5;
   localparam logic [2:0] S_ONE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [7:0]        cfg_w_ff, cfg_w_in;
   logic [7:0]        cfg_h_ff, cfg_h_in;
   logic [7:0]        act_w_ff, act_w_in;
   logic [7:0]        act_h_ff, act_h_in;
   logic              init_done_ff, init_done_in;
   logic              dirty_ff, dirty_in;
   logic [PAGE_W-1:0] cursor_ff, cursor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pend_ff, pend_in;

   logic [PAGE_W-1:0] page_ff, page_in;
   req_item_type      item_ff, item_in;
   logic [1:0]        status_ff, status_in;
   logic              clr_then_cmd_ff, clr_then_cmd_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              cmd_init_ff, cmd_init_in;
   logic [1:0]        cmd_idx_ff, cmd_idx_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [8:0]        pos_ff, pos_in;
   logic [3:0]        lane_cnt_ff, lane_cnt_in;
   logic [2:0]        pend_lane_ff, pend_lane_in;
   logic              first_ff, first_in;
   logic [7:0][7:0]   pack_ff, pack_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              accept;
   logic              emit_ok;
   logic              emit;
   logic [1:0]        em_status;
   logic [3:0]        em_count;
   logic [63:0]       em_payload;
   logic              em_start;
   logic              em_last;
   logic              cfg_bad;
   logic              px_in_range;
   logic [4:0]        pages;
   logic [5:0]        cur_step;
   logic              svc_wrap;
   logic              issue_ok;
   logic              chunk_ready;
   logic              data_done;
   logic              cmd_last;
   logic [7:0]        px_mask;
   logic [7:0]        px_byte;

   logic              mul_start;
   logic [PAGE_W-1:0] mul_page;
   logic [7:0]        mul_col;
   logic [ADDR_W-1:0] mul_res;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   pfs_addr_unit #(
      .PAGE_W (PAGE_W),
      .ADDR_W (ADDR_W)
   ) u_addr (
      .clock  (clock),
      .start  (mul_start),
      .page   (mul_page),
      .col    (mul_col),
      .width  (act_w_ff),
      .result (mul_res)
   );

   pfs_store #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign accept  = req_chan.valid && req_chan.ready;
   assign emit_ok = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      cfg_bad = (cfg_w_ff == 8'd0) || (cfg_w_ff > MAX_W8) || (cfg_h_ff == 8'd0) ||
                (cfg_h_ff > MAX_H8) || (cfg_h_ff[2:0] != 3'd0);
      px_in_range = (req_chan.payload.pixel_x < act_w_ff) &&
                    (req_chan.payload.pixel_y < act_h_ff);
      pages    = act_h_ff[7:3];
      cur_step = 6'(cursor_ff) + 6'd1;
      svc_wrap = cur_step >= {1'b0, pages};
      issue_ok = (lane_cnt_ff != BYTES_PER_RESULT) && (pos_ff <= {1'b0, act_w_ff});
      chunk_ready = !issue_ok && !pend_ff;
      data_done   = pos_ff > {1'b0, act_w_ff};
      cmd_last    = cmd_init_ff ? (cmd_idx_ff == INIT_CMD_LAST) : (cmd_idx_ff == SVC_CMD_LAST);
      px_mask = 8'd1 << item_ff.pixel_y[2:0];
      px_byte = item_ff.pixel_on ? (mem_rd_data | px_mask) : (mem_rd_data & ~px_mask);
   end

   // shared multiply-add: pixel offset or page base
   always_comb begin
      mul_start = accept && init_done_ff &&
                  (((req_chan.payload.mode == MODE_PIXEL) && px_in_range) ||
                   ((req_chan.payload.mode == MODE_SERVICE) && dirty_ff));
      if (req_chan.payload.mode == MODE_SERVICE) begin
         mul_page = cursor_ff;
         mul_col  = 8'd0;
      end else begin
         mul_page = PAGE_W'(req_chan.payload.pixel_y[7:3]);
         mul_col  = req_chan.payload.pixel_x;
      end
   end

   always_comb begin
      mem_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_PX_WR);
      mem_wr_addr = (state_ff == S_CLEAR) ? clr_addr_ff : mul_res;
      mem_wr_data = (state_ff == S_CLEAR) ? 8'd0 : px_byte;
      mem_rd_en   = (state_ff == S_PX_RD) ||
                    ((state_ff == S_DATA) && issue_ok && (pos_ff != 9'd0));
      mem_rd_addr = (state_ff == S_DATA) ? rd_addr_ff : mul_res;
   end

   always_comb begin
      state_in        = state_ff;
      cfg_w_in        = cfg_w_ff;
      cfg_h_in        = cfg_h_ff;
      act_w_in        = act_w_ff;
      act_h_in        = act_h_ff;
      init_done_in    = init_done_ff;
      dirty_in        = dirty_ff;
      cursor_in       = cursor_ff;
      pend_in         = pend_ff;
      page_in         = page_ff;
      item_in         = item_ff;
      status_in       = status_ff;
      clr_then_cmd_in = clr_then_cmd_ff;
      clr_addr_in     = clr_addr_ff;
      cmd_init_in     = cmd_init_ff;
      cmd_idx_in      = cmd_idx_ff;
      rd_addr_in      = rd_addr_ff;
      pos_in          = pos_ff;
      lane_cnt_in     = lane_cnt_ff;
      pend_lane_in    = pend_lane_ff;
      first_in        = first_ff;
      pack_in         = pack_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      emit            = 1'b0;
      em_status       = ST_OK;
      em_count        = 4'd0;
      em_payload      = 64'd0;
      em_start        = 1'b0;
      em_last         = 1'b0;

      if (csr_wr_en) begin
         if (csr_index == CSR_WIDTH) begin
            cfg_w_in = csr_wr_data;
         end else begin
            cfg_h_in = csr_wr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in     = req_chan.payload;
               cmd_idx_in  = 2'd0;
               clr_addr_in = '0;
               status_in   = ST_REJECT;
               state_in    = S_ONE;
               unique case (req_chan.payload.mode)
                  MODE_INIT: begin
                     if (cfg_bad) begin
                        status_in = ST_BAD_CFG;
                     end else begin
                        act_w_in        = cfg_w_ff;
                        act_h_in        = cfg_h_ff;
                        cursor_in       = '0;
                        dirty_in        = 1'b1;
                        init_done_in    = 1'b1;
                        cmd_init_in     = 1'b1;
                        clr_then_cmd_in = 1'b1;
                        status_in       = ST_OK;
                        state_in        = S_CLEAR;
                     end
                  end
                  MODE_CLEAR: begin
                     if (init_done_ff) begin
                        dirty_in        = 1'b1;
                        clr_then_cmd_in = 1'b0;
                        status_in       = ST_OK;
                        state_in        = S_CLEAR;
                     end
                  end
                  MODE_PIXEL: begin
                     if (init_done_ff && px_in_range) begin
                        dirty_in  = 1'b1;
                        status_in = ST_OK;
                        state_in  = S_PX_RD;
                     end
                  end
                  MODE_DIRTY: begin
                     if (init_done_ff) begin
                        dirty_in  = 1'b1;
                        status_in = ST_OK;
                     end
                  end
                  MODE_SERVICE: begin
                     if (init_done_ff) begin
                        status_in = ST_OK;
                        if (dirty_ff) begin
                           page_in     = cursor_ff;
                           cmd_init_in = 1'b0;
                           state_in    = S_CMD;
                           if (svc_wrap) begin
                              cursor_in = '0;
                              dirty_in  = 1'b0;
                           end else begin
                              cursor_in = cursor_ff + PAGE_W'(1);
                           end
                        end
                     end
                  end
                  default: begin
                     status_in = ST_REJECT;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = clr_then_cmd_ff ? S_CMD : S_ONE;
            end
         end
         S_PX_RD: begin
            state_in = S_PX_WR;
         end
         S_PX_WR: begin
            state_in = S_ONE;
         end
         S_ONE: begin
            if (emit_ok) begin
               emit      = 1'b1;
               em_status = status_ff;
               em_last   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CMD: begin
            if (emit_ok) begin
               emit       = 1'b1;
               em_count   = CMD_BYTES;
               em_payload = {48'd0, cmd_byte(cmd_init_ff, cmd_idx_ff, 8'(page_ff)), CMD_PREFIX};
               em_start   = 1'b1;
               em_last    = cmd_init_ff && cmd_last;
               cmd_idx_in = cmd_idx_ff + 2'd1;
               if (cmd_last) begin
                  if (cmd_init_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     rd_addr_in  = mul_res;
                     pos_in      = 9'd0;
                     lane_cnt_in = 4'd0;
                     pack_in     = '0;
                     first_in    = 1'b1;
                     state_in    = S_DATA;
                  end
               end
            end
         end
         S_DATA: begin
            // read data lands in the cycle after its address
            if (pend_ff) begin
               pack_in[pend_lane_ff] = mem_rd_data;
            end
            pend_in = 1'b0;
            if (issue_ok) begin
               if (pos_ff == 9'd0) begin
                  pack_in[lane_cnt_ff[2:0]] = DATA_PREFIX;
               end else begin
                  pend_in      = 1'b1;
                  pend_lane_in = lane_cnt_ff[2:0];
                  rd_addr_in   = rd_addr_ff + ADDR_W'(1);
               end
               pos_in      = pos_ff + 9'd1;
               lane_cnt_in = lane_cnt_ff + 4'd1;
            end else if (chunk_ready && emit_ok) begin
               emit       = 1'b1;
               em_count   = lane_cnt_ff;
               em_payload = pack_ff;
               em_start   = first_ff;
               em_last    = data_done;
               if (data_done) begin
                  state_in = S_IDLE;
               end else begin
                  lane_cnt_in = 4'd0;
                  pack_in     = '0;
                  first_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = em_status;
         rsp_in.dirty_now      = dirty_ff;
         rsp_in.byte_count     = em_count;
         rsp_in.payload        = em_payload;
         rsp_in.transfer_start = em_start;
         rsp_in.last           = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_w_ff     <= CFG_WIDTH_RST;
         cfg_h_ff     <= CFG_HEIGHT_RST;
         act_w_ff     <= 8'd0;
         act_h_ff     <= 8'd0;
         init_done_ff <= 1'b0;
         dirty_ff     <= 1'b0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         act_w_ff     <= act_w_in;
         act_h_ff     <= act_h_in;
         init_done_ff <= init_done_in;
         dirty_ff     <= dirty_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      item_ff         <= item_in;
      status_ff       <= status_in;
      clr_then_cmd_ff <= clr_then_cmd_in;
      clr_addr_ff     <= clr_addr_in;
      cmd_init_ff     <= cmd_init_in;
      cmd_idx_ff      <= cmd_idx_in;
      rd_addr_ff      <= rd_addr_in;
      pos_ff          <= pos_in;
      lane_cnt_ff     <= lane_cnt_in;
      pend_lane_ff    <= pend_lane_in;
      first_ff        <= first_in;
      pack_ff         <= pack_in;
      rsp_ff          <= rsp_in;
   end

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && em_last) |=> state_ff == S_IDLE)
      else $error("sequencer busy after final result");

   a_pend_data: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == S_DATA)
      else $error("store read pending outside page scan-out");

   a_clear_geom: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (init_done_ff && act_w_ff != 8'd0 && act_h_ff[2:0] == 3'd0))
      else $error("store sweep without a valid geometry");

endmodule
